[hdl/trt_pkg.sv]
// Package for the traffic report trigger: field widths, register indexes,
// word kind codes and reset values. No dependencies.
package trt_pkg;

   // Input word fields.
   localparam int MODE_W     = 2;
   localparam int PAYLOAD_W  = 17;

   // Counter and result widths.
   localparam int ELAPSED_W  = 32;
   localparam int WBYTES_W   = 40;
   localparam int WPKTS_W    = 32;
   localparam int SBYTES_W   = 48;
   localparam int SPKTS_W    = 40;
   localparam int RATE_W     = 56;

   // Configuration registers.
   localparam int HEARTBEAT_W = 22;
   localparam int LIMIT_W     = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PACKET_LIMIT = 2'd2;

   localparam logic [HEARTBEAT_W-1:0] HEARTBEAT_RESET = 22'd60000;

   // Word kinds.
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PACKET = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POLL   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Default number of fraction bits of the byte rate (legal range 8 to 24).
   localparam int RATE_FRACTION_BITS_DEF = 16;

endpackage

[hdl/trt_if.sv]
// Channel interfaces of the traffic report trigger: the request channel
// (word kind and payload length) and the report channel. Uses trt_pkg.
interface trt_req_if
   import trt_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [PAYLOAD_W-1:0] payload_length;

   modport source (output valid, output mode, output payload_length, input ready);
   modport sink   (input valid, input mode, input payload_length, output ready);
   modport mon    (input valid, input mode, input payload_length, input ready);
endinterface

interface trt_rsp_if
   import trt_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [ELAPSED_W-1:0] interval_ms;
   logic [WBYTES_W-1:0]  interval_bytes;
   logic [WPKTS_W-1:0]   interval_packets;
   logic [SBYTES_W-1:0]  total_bytes_before;
   logic [SPKTS_W-1:0]   total_packets_before;

   modport source (output valid, output interval_ms, output interval_bytes,
                   output interval_packets, output total_bytes_before,
                   output total_packets_before, input ready);
   modport sink   (input valid, input interval_ms, input interval_bytes,
                   input interval_packets, input total_bytes_before,
                   input total_packets_before, output ready);
   modport mon    (input valid, input interval_ms, input interval_bytes,
                   input interval_packets, input total_bytes_before,
                   input total_packets_before, input ready);
endinterface

[hdl/trt_divider.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module trt_divider #(
   parameter int DIVIDEND_W = 56,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         count_in = CNT_W'(DIVIDEND_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[hdl/traffic_report_trigger_unit.sv]
// Top level of the traffic report trigger: sequencer, counters, rate test
// and report register. Uses trt_pkg, trt_if.sv and trt_divider.
//
//   channel    direction  handshake          word
//   req_chan   in         valid / ready      mode, payload_length
//   rsp_chan   out        valid / ready      interval and total counters
//   csr_*      in         csr_write_en       csr_index, csr_write_data
//
// A tick, an unused word kind, or an idle poll with the heartbeat at zero
// is handled in the idle state alone. A packet, or a poll with the heartbeat
// set, goes on to the decide state, then to the report state when it reports.
// When the rate is computed, the word passes from the decide state through the
// divider stage and the two compare states. Reset is synchronous and
// active high; it restores the register defaults and clears all counters. A
// report waits in the output register until taken; a later word that reports
// while it still waits holds the sequencer until the register is free.
module traffic_report_trigger_unit
   import trt_pkg::*;
#(
   parameter int RATE_FRACTION_BITS = RATE_FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   trt_req_if.sink                req_chan,
   trt_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   // The dividend is the window byte count with the fraction bits appended.
   localparam int DIV_W = WBYTES_W + RATE_FRACTION_BITS;
   localparam int QX_W  = (DIV_W > RATE_W) ? DIV_W : RATE_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_CMP1   = 3'd3;
   localparam logic [2:0] ST_CMP2   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;

   logic [HEARTBEAT_W-1:0] heartbeat_ff, heartbeat_in;
   logic [LIMIT_W-1:0]     byte_limit_ff, byte_limit_in;
   logic [LIMIT_W-1:0]     packet_limit_ff, packet_limit_in;

   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic [WBYTES_W-1:0]    wbytes_ff, wbytes_in;
   logic [WPKTS_W-1:0]     wpkts_ff, wpkts_in;
   logic [SBYTES_W-1:0]    sbytes_ff, sbytes_in;
   logic [SPKTS_W-1:0]     spkts_ff, spkts_in;
   logic [RATE_W-1:0]      cur_rate_ff, cur_rate_in;
   logic [RATE_W-1:0]      prev_rate_ff, prev_rate_in;

   logic [RATE_W-1:0]      hi_ff, hi_in;
   logic [RATE_W-1:0]      lo_ff, lo_in;
   logic                   neq_ff, neq_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ELAPSED_W-1:0]   out_ms_ff, out_ms_in;
   logic [WBYTES_W-1:0]    out_bytes_ff, out_bytes_in;
   logic [WPKTS_W-1:0]     out_pkts_ff, out_pkts_in;
   logic [SBYTES_W-1:0]    out_sbytes_ff, out_sbytes_in;
   logic [SPKTS_W-1:0]     out_spkts_ff, out_spkts_in;

   logic                   req_accept;
   logic                   div_start;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quotient;
   logic [QX_W-1:0]        quot_ext;

   // Saturating sums, one bit wider than the counter to expose the carry.
   logic [WBYTES_W:0]      wbytes_sum;
   logic [SBYTES_W:0]      sbytes_sum;
   logic [SPKTS_W:0]       spkts_sum;
   logic [RATE_W+3:0]      ten_lo;
   logic                   t_heartbeat;
   logic                   t_bytes;
   logic                   t_packets;
   logic                   varied;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign wbytes_sum = {1'b0, wbytes_ff} + (WBYTES_W + 1)'(req_chan.payload_length);
   assign sbytes_sum = {1'b0, sbytes_ff} + (SBYTES_W + 1)'(wbytes_ff);
   assign spkts_sum  = {1'b0, spkts_ff} + (SPKTS_W + 1)'(wpkts_ff);

   // Tests in the order the report decision takes them.
   assign t_heartbeat = (elapsed_ff >= ELAPSED_W'(heartbeat_ff));
   assign t_bytes     = (byte_limit_ff != '0) && (wbytes_ff >= WBYTES_W'(byte_limit_ff));
   assign t_packets   = (packet_limit_ff != '0) && (spkts_ff >= SPKTS_W'(packet_limit_ff));

   // Ten times the smaller rate, formed as 8x + 2x.
   assign ten_lo = {1'b0, lo_ff, 3'b000} + {3'b000, lo_ff, 1'b0};
   assign varied = neq_ff && ((lo_ff == '0) || ({4'b0000, hi_ff} > ten_lo));

   assign quot_ext = QX_W'(div_quotient);

   trt_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (ELAPSED_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({wbytes_ff, {RATE_FRACTION_BITS{1'b0}}}),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      heartbeat_in    = heartbeat_ff;
      byte_limit_in   = byte_limit_ff;
      packet_limit_in = packet_limit_ff;
      elapsed_in      = elapsed_ff;
      wbytes_in       = wbytes_ff;
      wpkts_in        = wpkts_ff;
      sbytes_in       = sbytes_ff;
      spkts_in        = spkts_ff;
      cur_rate_in     = cur_rate_ff;
      prev_rate_in    = prev_rate_ff;
      hi_in           = hi_ff;
      lo_in           = lo_ff;
      neq_in          = neq_ff;
      out_ms_in       = out_ms_ff;
      out_bytes_in    = out_bytes_ff;
      out_pkts_in     = out_pkts_ff;
      out_sbytes_in   = out_sbytes_ff;
      out_spkts_in    = out_spkts_ff;
      div_start       = 1'b0;

      // The report register drops its word once the sink takes it.
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (csr_write_en) begin
         case (csr_index)
            CSR_HEARTBEAT:    heartbeat_in    = csr_write_data[HEARTBEAT_W-1:0];
            CSR_BYTE_LIMIT:   byte_limit_in   = csr_write_data[LIMIT_W-1:0];
            CSR_PACKET_LIMIT: packet_limit_in = csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in = req_chan.mode;
               case (req_chan.mode)
                  MODE_TICK: begin
                     if (elapsed_ff != '1) begin
                        elapsed_in = elapsed_ff + 1'b1;
                     end
                  end
                  MODE_PACKET: begin
                     wbytes_in = wbytes_sum[WBYTES_W] ? '1 : wbytes_sum[WBYTES_W-1:0];
                     if (wpkts_ff != '1) begin
                        wpkts_in = wpkts_ff + 1'b1;
                     end
                     state_in = ST_DECIDE;
                  end
                  MODE_POLL: begin
                     // With the heartbeat at zero an idle poll does nothing.
                     if (heartbeat_ff != '0) begin
                        state_in = ST_DECIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DECIDE: begin
            if (t_heartbeat ||
                (mode_ff == MODE_PACKET && (t_bytes || t_packets))) begin
               state_in = ST_EMIT;
            end else if (elapsed_ff == '0) begin
               // No rate can be formed without elapsed time; the rate is kept.
               if (mode_ff == MODE_POLL && cur_rate_ff != '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               cur_rate_in = (quot_ext > QX_W'({RATE_W{1'b1}})) ? '1
                                                                : quot_ext[RATE_W-1:0];
               state_in = ST_CMP1;
            end
         end
         ST_CMP1: begin
            neq_in = (cur_rate_ff != prev_rate_ff);
            if (cur_rate_ff > prev_rate_ff) begin
               hi_in = cur_rate_ff;
               lo_in = prev_rate_ff;
            end else begin
               hi_in = prev_rate_ff;
               lo_in = cur_rate_ff;
            end
            state_in = ST_CMP2;
         end
         ST_CMP2: begin
            if (varied || (mode_ff == MODE_POLL && cur_rate_ff != '0)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               out_ms_in     = elapsed_ff;
               out_bytes_in  = wbytes_ff;
               out_pkts_in   = wpkts_ff;
               out_sbytes_in = sbytes_ff;
               out_spkts_in  = spkts_ff;
               sbytes_in     = sbytes_sum[SBYTES_W] ? '1 : sbytes_sum[SBYTES_W-1:0];
               spkts_in      = spkts_sum[SPKTS_W] ? '1 : spkts_sum[SPKTS_W-1:0];
               wbytes_in     = '0;
               wpkts_in      = '0;
               prev_rate_in  = cur_rate_ff;
               elapsed_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         heartbeat_ff    <= HEARTBEAT_RESET;
         byte_limit_ff   <= '0;
         packet_limit_ff <= '0;
         elapsed_ff      <= '0;
         wbytes_ff       <= '0;
         wpkts_ff        <= '0;
         sbytes_ff       <= '0;
         spkts_ff        <= '0;
         cur_rate_ff     <= '0;
         prev_rate_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         heartbeat_ff    <= heartbeat_in;
         byte_limit_ff   <= byte_limit_in;
         packet_limit_ff <= packet_limit_in;
         elapsed_ff      <= elapsed_in;
         wbytes_ff       <= wbytes_in;
         wpkts_ff        <= wpkts_in;
         sbytes_ff       <= sbytes_in;
         spkts_ff        <= spkts_in;
         cur_rate_ff     <= cur_rate_in;
         prev_rate_ff    <= prev_rate_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      neq_ff        <= neq_in;
      out_ms_ff     <= out_ms_in;
      out_bytes_ff  <= out_bytes_in;
      out_pkts_ff   <= out_pkts_in;
      out_sbytes_ff <= out_sbytes_in;
      out_spkts_ff  <= out_spkts_in;
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.interval_ms          = out_ms_ff;
   assign rsp_chan.interval_bytes       = out_bytes_ff;
   assign rsp_chan.interval_packets     = out_pkts_ff;
   assign rsp_chan.total_bytes_before   = out_sbytes_ff;
   assign rsp_chan.total_packets_before = out_spkts_ff;
endmodule

[hdl/trt_checker.sv]
// Port-level checks for the traffic report trigger, bound to the top level.
// Uses trt_pkg; the bind hands in the channel signals of the top level.
module trt_checker
   import trt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [MODE_W-1:0]   req_mode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [WBYTES_W-1:0] rsp_interval_bytes,
   input logic [SBYTES_W-1:0] rsp_total_bytes_before
);
   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // A waiting report word holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_interval_bytes) &&
         $stable(rsp_total_bytes_before))
      else $error("report word changed while stalled");

   // A packet always needs the decision step, so the request side closes.
   a_packet_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_mode == MODE_PACKET |=> !req_ready)
      else $error("ready stayed high after a packet word");

   // Ticks and unused word kinds are absorbed without leaving the idle state.
   a_tick_fast: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_mode == MODE_TICK || req_mode == MODE_UNUSED)
         |=> req_ready)
      else $error("ready dropped after a tick word");

   // A new report is loaded only from the report state, never while idle.
   a_report_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("report appeared while the request side was open");
endmodule

bind traffic_report_trigger_unit trt_checker u_trt_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_chan.valid),
   .req_ready              (req_chan.ready),
   .req_mode               (req_chan.mode),
   .rsp_valid              (rsp_chan.valid),
   .rsp_ready              (rsp_chan.ready),
   .rsp_interval_bytes     (rsp_chan.interval_bytes),
   .rsp_total_bytes_before (rsp_chan.total_bytes_before)
);

[sim/tb.sv]
// Self-checking bench for traffic_report_trigger_unit: a scripted opening, then random
// blocks of words, with every report checked against an in-bench model of the trigger.
// Depends on trt_pkg, the channel interfaces in trt_if.sv and the unit's RTL.
module tb;
   import trt_pkg::*;

   localparam int FRAC_BITS = RATE_FRACTION_BITS_DEF;

   // Index 3 addresses no register; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [63:0] RATE_SAT = (64'd1 << RATE_W) - 64'd1;

   // The quiet stretch after the last report covers a rate word that runs
   // through the serial divider and ends without one.
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 700;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_BLOCKS = 9;
   localparam int BLOCK_WORDS   = 50;

   // One report word as the unit hands it out.
   typedef struct packed {
      logic [ELAPSED_W-1:0] ms;
      logic [WBYTES_W-1:0]  bytes;
      logic [WPKTS_W-1:0]   packets;
      logic [SBYTES_W-1:0]  base_bytes;
      logic [SPKTS_W-1:0]   base_pkts;
   } report_type;

   // One line of the opening script: either a register write or a request word.
   // Where typed is set, the outcome is written into the line itself.
   typedef struct packed {
      bit                     csr;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      logic [MODE_W-1:0]      mode;
      logic [PAYLOAD_W-1:0]   len;
      bit                     typed;
      bit                     fires;
      report_type             want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   trt_req_if req_bus ();
   trt_rsp_if rsp_bus ();

   traffic_report_trigger_unit #(
      .RATE_FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model of the trigger: register copies, the interval window, the running
   // totals and the two rates.
   logic [HEARTBEAT_W-1:0] hb_cfg;
   logic [LIMIT_W-1:0]     byte_lim_cfg;
   logic [LIMIT_W-1:0]     pkt_lim_cfg;
   logic [ELAPSED_W-1:0]   ms_count;
   logic [WBYTES_W-1:0]    win_bytes;
   logic [WPKTS_W-1:0]     win_pkts;
   logic [SBYTES_W-1:0]    run_bytes;
   logic [SPKTS_W-1:0]     run_pkts;
   logic [RATE_W-1:0]      rate_now;
   logic [RATE_W-1:0]      rate_last;

   report_type     pending_reports[$];
   script_row_type script[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 35;
   int  recv_idle_pct = 81;
   int  hold_left = 0;
   bit  hold_request = 1'b0;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, int w);
      logic [63:0] top;
      top = (64'd1 << w) - 64'd1;
      return (a + b > top) ? top : a + b;
   endfunction

   // Recomputes the current byte rate from the window and tells whether it moved
   // more than tenfold from the rate of the last report. With no elapsed time the
   // current rate is left as it was.
   function automatic bit rate_jumped();
      logic [63:0]       quotient;
      logic [RATE_W-1:0] rate_hi;
      logic [RATE_W-1:0] rate_lo;
      if (ms_count == '0)
         return 1'b0;
      quotient = ({24'd0, win_bytes} << FRAC_BITS) / {32'd0, ms_count};
      rate_now = (quotient > RATE_SAT) ? RATE_SAT[RATE_W-1:0] : quotient[RATE_W-1:0];
      rate_hi = (rate_now > rate_last) ? rate_now : rate_last;
      rate_lo = (rate_now > rate_last) ? rate_last : rate_now;
      return (rate_hi != rate_lo) &&
             (rate_lo == '0 || {8'd0, rate_hi} > 64'd10 * {8'd0, rate_lo});
   endfunction

   // Advances the model by one accepted word; returns 1 and fills r when the
   // word triggers a report.
   function automatic bit meter_step(input logic [MODE_W-1:0] m,
                                     input logic [PAYLOAD_W-1:0] len,
                                     output report_type r);
      bit fire;
      fire = 1'b0;
      r = '0;
      case (m)
         MODE_TICK: ms_count = ELAPSED_W'(sat_add(64'(ms_count), 64'd1, ELAPSED_W));
         MODE_PACKET: begin
            win_bytes = WBYTES_W'(sat_add(64'(win_bytes), 64'(len), WBYTES_W));
            win_pkts = WPKTS_W'(sat_add(64'(win_pkts), 64'd1, WPKTS_W));
            if (ms_count >= hb_cfg)
               fire = 1'b1;
            else if (byte_lim_cfg != 0 && win_bytes >= byte_lim_cfg)
               fire = 1'b1;
            else if (pkt_lim_cfg != 0 && run_pkts >= pkt_lim_cfg)
               fire = 1'b1;
            else
               fire = rate_jumped();
         end
         MODE_POLL: begin
            // Short-circuit order matters: the rate is only recomputed when the
            // heartbeat has not yet run out.
            if (hb_cfg != 0) begin
               if (ms_count >= hb_cfg)
                  fire = 1'b1;
               else if (rate_jumped())
                  fire = 1'b1;
               else
                  fire = (rate_now != 0);
            end
         end
         default: ;
      endcase
      if (fire) begin
         r.ms = ms_count;
         r.bytes = win_bytes;
         r.packets = win_pkts;
         r.base_bytes = run_bytes;
         r.base_pkts = run_pkts;
         run_bytes = SBYTES_W'(sat_add(64'(run_bytes), 64'(win_bytes), SBYTES_W));
         run_pkts = SPKTS_W'(sat_add(64'(run_pkts), 64'(win_pkts), SPKTS_W));
         win_bytes = '0;
         win_pkts = '0;
         rate_last = rate_now;
         ms_count = '0;
      end
      return fire;
   endfunction

   function automatic script_row_type word_row(logic [MODE_W-1:0] m,
                                               logic [PAYLOAD_W-1:0] len);
      script_row_type s;
      s = '0;
      s.mode = m;
      s.len = len;
      return s;
   endfunction

   function automatic script_row_type known_row(logic [MODE_W-1:0] m,
                                                logic [PAYLOAD_W-1:0] len,
                                                bit fires, report_type want);
      script_row_type s;
      s = word_row(m, len);
      s.typed = 1'b1;
      s.fires = fires;
      s.want = want;
      return s;
   endfunction

   function automatic script_row_type reg_row(logic [CSR_INDEX_W-1:0] idx,
                                              logic [CSR_DATA_W-1:0] value);
      script_row_type s;
      s = '0;
      s.csr = 1'b1;
      s.idx = idx;
      s.data = value;
      return s;
   endfunction

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Presents one word at a falling edge, after a random number of idle cycles,
   // and returns at the rising edge where it is taken. Valid is left high so
   // that back-to-back words never lower and raise it in the same step.
   task automatic offer_word(input logic [MODE_W-1:0] m, input logic [PAYLOAD_W-1:0] len);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= m;
      req_bus.payload_length <= len;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // Stops offering and waits until every predicted report has come back, then
   // gives a word that ends without a report time to leave the divider.
   task automatic drain_reports();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_HEARTBEAT:    hb_cfg = value[HEARTBEAT_W-1:0];
         CSR_BYTE_LIMIT:   byte_lim_cfg = value[LIMIT_W-1:0];
         CSR_PACKET_LIMIT: pkt_lim_cfg = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Receiver: ready changes at the falling edge. A long hold, once asked for by
   // the stimulus, is counted out here so the unit backs up into its input.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every report word taken is compared field by field with the oldest
   // prediction.
   always @(posedge clock) begin : check_reports
      report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            log_mismatch("report with none pending", 64'(rsp_bus.interval_ms), 64'd0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_bus.interval_ms !== want.ms)
               log_mismatch("interval_ms", 64'(rsp_bus.interval_ms), 64'(want.ms));
            if (rsp_bus.interval_bytes !== want.bytes)
               log_mismatch("interval_bytes", 64'(rsp_bus.interval_bytes),
                            64'(want.bytes));
            if (rsp_bus.interval_packets !== want.packets)
               log_mismatch("interval_packets", 64'(rsp_bus.interval_packets),
                            64'(want.packets));
            if (rsp_bus.total_bytes_before !== want.base_bytes)
               log_mismatch("total_bytes_before", 64'(rsp_bus.total_bytes_before),
                            64'(want.base_bytes));
            if (rsp_bus.total_packets_before !== want.base_pkts)
               log_mismatch("total_packets_before", 64'(rsp_bus.total_packets_before),
                            64'(want.base_pkts));
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("traffic_report_trigger_unit verification failed");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      report_type     r;
      bit             fired;
      int             counted;
      logic [MODE_W-1:0]     m;
      logic [PAYLOAD_W-1:0]  len;
      logic [CSR_DATA_W-1:0] value;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_HEARTBEAT;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_TICK;
      req_bus.payload_length = '0;
      rsp_bus.ready = 1'b0;

      hb_cfg = HEARTBEAT_RESET;
      byte_lim_cfg = '0;
      pkt_lim_cfg = '0;
      ms_count = '0;
      win_bytes = '0;
      win_pkts = '0;
      run_bytes = '0;
      run_pkts = '0;
      rate_now = '0;
      rate_last = '0;

      // Opening script. Right after reset the heartbeat is long and both limits
      // are off, so the first few outcomes can be worked out by hand.
      script.push_back(known_row(MODE_POLL, 17'd0, 1'b0, '0));
      script.push_back(known_row(MODE_PACKET, 17'd0, 1'b0, '0));
      script.push_back(known_row(MODE_TICK, 17'd0, 1'b0, '0));
      // One millisecond and 64 KiB: the rate jumps up from zero.
      script.push_back(known_row(MODE_PACKET, 17'd65536, 1'b1,
                                 '{ms: 32'd1, bytes: 40'd65536, packets: 32'd2,
                                   base_bytes: 48'd0, base_pkts: 40'd0}));
      script.push_back(known_row(MODE_UNUSED, 17'h1FFFF, 1'b0, '0));
      // A poll right after a report: no time has passed, but the carried rate is
      // nonzero, so an empty report goes out.
      script.push_back(known_row(MODE_POLL, 17'd0, 1'b1,
                                 '{ms: 32'd0, bytes: 40'd0, packets: 32'd0,
                                   base_bytes: 48'd65536, base_pkts: 40'd2}));
      // A length beyond 64 KiB is counted as given.
      script.push_back(known_row(MODE_PACKET, 17'h1FFFF, 1'b0, '0));
      script.push_back(word_row(MODE_TICK, 17'd0));
      script.push_back(word_row(MODE_PACKET, 17'd1));
      script.push_back(word_row(MODE_TICK, 17'd0));
      script.push_back(word_row(MODE_TICK, 17'd0));
      script.push_back(word_row(MODE_POLL, 17'd0));
      // Heartbeat zero: polls stay silent while every packet reports.
      script.push_back(reg_row(CSR_HEARTBEAT, 31'd0));
      script.push_back(known_row(MODE_POLL, 17'd0, 1'b0, '0));
      script.push_back(word_row(MODE_PACKET, 17'd5));
      script.push_back(word_row(MODE_TICK, 17'd0));
      script.push_back(word_row(MODE_PACKET, 17'd0));
      // A long heartbeat with a small byte limit that the window reaches.
      script.push_back(reg_row(CSR_HEARTBEAT, 31'd3600000));
      script.push_back(reg_row(CSR_BYTE_LIMIT, 31'd100));
      script.push_back(word_row(MODE_PACKET, 17'd99));
      script.push_back(word_row(MODE_PACKET, 17'd1));
      // The packet limit is compared against the totals before this interval.
      script.push_back(reg_row(CSR_BYTE_LIMIT, 31'h7FFFFFFF));
      script.push_back(reg_row(CSR_PACKET_LIMIT, 31'd1));
      script.push_back(word_row(MODE_PACKET, 17'd7));
      script.push_back(reg_row(CSR_PACKET_LIMIT, 31'h7FFFFFFF));
      script.push_back(reg_row(CSR_SPARE, 31'h7FFFFFFF));
      script.push_back(word_row(MODE_TICK, 17'd0));
      script.push_back(word_row(MODE_PACKET, 17'd0));
      script.push_back(word_row(MODE_TICK, 17'd0));
      script.push_back(word_row(MODE_POLL, 17'd0));
      // Heartbeat data wider than the register keeps only its low bits.
      script.push_back(reg_row(CSR_HEARTBEAT, 31'h7FFFFFFF));
      script.push_back(word_row(MODE_PACKET, 17'd1500));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.csr) begin
            drain_reports();
            write_reg(row.idx, row.data);
         end else begin
            offer_word(row.mode, row.len);
            fired = meter_step(row.mode, row.len, r);
            if (row.typed) begin
               if (row.fires)
                  pending_reports.push_back(row.want);
            end else if (fired) begin
               pending_reports.push_back(r);
            end
         end
      end

      // Random blocks. Each block starts idle with fresh register settings; the
      // idle profile moves from a slow receiver to a slow sender to none at all.
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         drain_reports();
         case (blk / 3)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         case ($urandom_range(5))
            0: value = 31'd0;
            1: value = 31'd1;
            2: value = CSR_DATA_W'($urandom_range(40, 2));
            3: value = 31'd3600000;
            4: value = CSR_DATA_W'($urandom());
            default: value = CSR_DATA_W'($urandom_range(500, 41));
         endcase
         write_reg(CSR_HEARTBEAT, value);
         case ($urandom_range(4))
            0: value = 31'd0;
            1: value = 31'd1;
            2: value = CSR_DATA_W'($urandom_range(300000, 1000));
            3: value = 31'h7FFFFFFF;
            default: value = CSR_DATA_W'($urandom());
         endcase
         write_reg(CSR_BYTE_LIMIT, value);
         case ($urandom_range(3))
            0: value = 31'd0;
            1: value = CSR_DATA_W'($urandom_range(60, 1));
            2: value = 31'h7FFFFFFF;
            default: value = CSR_DATA_W'($urandom());
         endcase
         write_reg(CSR_PACKET_LIMIT, value);
         if ($urandom_range(3) == 0)
            write_reg(CSR_SPARE, CSR_DATA_W'($urandom()));

         counted = 0;
         while (counted < BLOCK_WORDS) begin
            // Once, the sender stops until all reports are home; once, the
            // receiver blocks for a long stretch while words keep coming.
            if (blk == 0 && counted == 25)
               drain_reports();
            if (blk == 6 && counted == 5)
               hold_request = 1'b1;

            case ($urandom_range(99)) inside
               [0:39]:  m = MODE_TICK;
               [40:79]: m = MODE_PACKET;
               [80:94]: m = MODE_POLL;
               default: m = MODE_UNUSED;
            endcase
            case ($urandom_range(9))
               0: len = '0;
               1: len = 17'd65536;
               2: len = '1;
               3, 4, 5: len = PAYLOAD_W'($urandom_range(1500));
               default: len = PAYLOAD_W'($urandom());
            endcase

            offer_word(m, len);
            if (meter_step(m, len, r))
               pending_reports.push_back(r);
            if (m != MODE_UNUSED)
               counted++;
         end
      end

      drain_reports();
      if (mismatch_count == 0) begin
         $display("traffic_report_trigger_unit verification clean");
      end else begin
         $display("traffic_report_trigger_unit verification failed");
      end
      $finish;
   end

endmodule
